// ===== rtl/rab_pkg.sv =====
// Shared types and constants for the RGB565 alpha blit block.
package rab_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Fixed field widths
    localparam int PIX_W     = 16;
    localparam int ALPHA_W   = 8;
    localparam int OPACITY_W = 9;
    localparam int CFG_IDX_W = 3;

    // Field constants
    localparam logic [OPACITY_W-1:0] OPACITY_FULL = 9'd256;
    localparam logic [ALPHA_W-1:0]   ALPHA_OPAQUE = 8'd255;

    // RGB565 channel layout
    localparam int R_LSB = 11;
    localparam int G_LSB = 5;
    localparam int B_LSB = 0;
    localparam int R_W   = 5;
    localparam int G_W   = 6;
    localparam int B_W   = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_LEFT      = 3'd0,
        REG_CLIP_TOP       = 3'd1,
        REG_CLIP_RIGHT     = 3'd2,
        REG_CLIP_BOTTOM    = 3'd3,
        REG_GLOBAL_OPACITY = 3'd4
    } rab_reg_e;

    // Classified pixel handed from the front end to the blend unit
    typedef struct packed {
        logic               we;       // pixel gets written
        logic [ALPHA_W-1:0] alpha;    // coverage after opacity scaling
        logic [PIX_W-1:0]   dpx;      // current frame pixel
        logic [PIX_W-1:0]   spx;      // sprite pixel
    } rab_item_t;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } rab_qstat_t;

endpackage

// ===== rtl/rab_front.sv =====
// Front end: configuration registers, input transfer, clip test and opacity scaling.
module rab_front import rab_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [((COORD_BITS > OPACITY_W) ? COORD_BITS : OPACITY_W)-1:0] cfg_data,
    // input stream
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [((2*(COORD_BITS+1) + 2*PIX_W + ALPHA_W + 7) / 8) * 8 - 1:0] s_data,
    // classified items toward the queue
    output logic                   f_valid,
    input  logic                   f_ready,
    output rab_item_t              f_item
);

    localparam int CW     = COORD_BITS + 1;
    localparam int LOW_W  = COORD_BITS - 1;
    localparam int HIGH_W = COORD_BITS;
    localparam int DPX_LSB = 2 * CW;
    localparam int SPX_LSB = DPX_LSB + PIX_W;
    localparam int A_LSB   = SPX_LSB + PIX_W;

    logic [LOW_W-1:0]     clip_left_reg;
    logic [LOW_W-1:0]     clip_top_reg;
    logic [HIGH_W-1:0]    clip_right_reg;
    logic [HIGH_W-1:0]    clip_bottom_reg;
    logic [OPACITY_W-1:0] opacity_reg;

    logic                  valid_reg;
    rab_item_t             item_reg;
    rab_item_t             item_next;

    logic signed [CW-1:0]  col;
    logic signed [CW-1:0]  row;
    logic [ALPHA_W-1:0]    alpha_in;
    logic [2*ALPHA_W-1:0]  alpha_prod;
    logic                  in_window;
    logic                  accept;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= {1'b1, {(HIGH_W-1){1'b0}}};
            clip_bottom_reg <= {1'b1, {(HIGH_W-1){1'b0}}};
            opacity_reg     <= OPACITY_FULL;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CLIP_LEFT:      clip_left_reg   <= cfg_data[LOW_W-1:0];
                REG_CLIP_TOP:       clip_top_reg    <= cfg_data[LOW_W-1:0];
                REG_CLIP_RIGHT:     clip_right_reg  <= cfg_data[HIGH_W-1:0];
                REG_CLIP_BOTTOM:    clip_bottom_reg <= cfg_data[HIGH_W-1:0];
                REG_GLOBAL_OPACITY: opacity_reg     <= cfg_data[OPACITY_W-1:0];
                default: ;
            endcase
        end
    end

    // Field unpacking
    assign col      = $signed(s_data[CW-1:0]);
    assign row      = $signed(s_data[2*CW-1:CW]);
    assign alpha_in = s_data[A_LSB +: ALPHA_W];

    // Clip window test, bounds zero-extended into the signed coordinate range
    assign in_window = (col >= $signed({2'b00, clip_left_reg}))  &&
                       (col <  $signed({1'b0, clip_right_reg}))  &&
                       (row >= $signed({2'b00, clip_top_reg}))   &&
                       (row <  $signed({1'b0, clip_bottom_reg}));

    // Opacity scaling; 256 and above leaves the coverage as is
    assign alpha_prod = alpha_in * opacity_reg[ALPHA_W-1:0];

    always_comb begin
        item_next.we    = in_window && (alpha_in != '0);
        item_next.alpha = (opacity_reg >= OPACITY_FULL) ? alpha_in
                                                        : alpha_prod[2*ALPHA_W-1:ALPHA_W];
        item_next.dpx   = s_data[DPX_LSB +: PIX_W];
        item_next.spx   = s_data[SPX_LSB +: PIX_W];
    end

    // Single register stage toward the queue
    assign s_ready = !valid_reg || f_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// ===== rtl/rab_fifo.sv =====
// Short queue of classified items between the front end and the blend unit.
module rab_fifo import rab_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  rab_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output rab_item_t  out_item,
    output rab_qstat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    rab_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

    assign in_ready  = !stat.full;
    assign out_valid = !stat.empty;
    assign out_item  = mem_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/rab_back.sv =====
// Blend unit: per-channel products, then channel sums, source copy or pass-through.
module rab_back import rab_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rab_item_t        in_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_data,
    output logic             m_user
);

    localparam int V_W = 15;
    localparam int Q_W = 7;
    // bias of 64*256 keeps s*a - d*a non-negative
    localparam logic [V_W-1:0] MIX_BIAS = 15'd16384;

    // s*a + bias - d*a for one channel of up to six bits
    function automatic logic [V_W-1:0] mix_prod(input logic [G_W-1:0] d,
                                                input logic [G_W-1:0] s,
                                                input logic [ALPHA_W-1:0] a);
        logic [V_W-1:0] sa;
        logic [V_W-1:0] da;
        sa = V_W'(s) * V_W'(a);
        da = V_W'(d) * V_W'(a);
        return sa + MIX_BIAS - da;
    endfunction

    // Stage 1 registers
    logic             b1_valid_reg;
    logic             b1_we_reg;
    logic             b1_opaque_reg;
    logic [PIX_W-1:0] b1_dpx_reg;
    logic [PIX_W-1:0] b1_spx_reg;
    logic [V_W-1:0]   b1_vr_reg;
    logic [V_W-1:0]   b1_vg_reg;
    logic [V_W-1:0]   b1_vb_reg;

    // Output registers
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_data_reg;
    logic             m_user_reg;
    logic [PIX_W-1:0] m_data_next;

    logic             out_free;
    logic             in_take;
    logic [Q_W-1:0]   sum_r;
    logic [Q_W-1:0]   sum_g;
    logic [Q_W-1:0]   sum_b;

    assign out_free = !m_valid_reg || m_ready;
    assign in_ready = !b1_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    // Stage 1: channel products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            b1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            b1_we_reg     <= in_item.we;
            b1_opaque_reg <= (in_item.alpha >= ALPHA_OPAQUE);
            b1_dpx_reg    <= in_item.dpx;
            b1_spx_reg    <= in_item.spx;
            b1_vr_reg     <= mix_prod(G_W'(in_item.dpx[R_LSB +: R_W]),
                                      G_W'(in_item.spx[R_LSB +: R_W]), in_item.alpha);
            b1_vg_reg     <= mix_prod(in_item.dpx[G_LSB +: G_W],
                                      in_item.spx[G_LSB +: G_W], in_item.alpha);
            b1_vb_reg     <= mix_prod(G_W'(in_item.dpx[B_LSB +: B_W]),
                                      G_W'(in_item.spx[B_LSB +: B_W]), in_item.alpha);
        end
    end

    // Stage 2: d + (v >> 8) - 64; the -64 vanishes modulo the channel range
    assign sum_r = Q_W'(b1_dpx_reg[R_LSB +: R_W]) + b1_vr_reg[V_W-1 -: Q_W];
    assign sum_g = Q_W'(b1_dpx_reg[G_LSB +: G_W]) + b1_vg_reg[V_W-1 -: Q_W];
    assign sum_b = Q_W'(b1_dpx_reg[B_LSB +: B_W]) + b1_vb_reg[V_W-1 -: Q_W];

    always_comb begin
        if (!b1_we_reg) begin
            m_data_next = b1_dpx_reg;
        end else if (b1_opaque_reg) begin
            m_data_next = b1_spx_reg;
        end else begin
            m_data_next = {sum_r[R_W-1:0], sum_g[G_W-1:0], sum_b[B_W-1:0]};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && b1_valid_reg) begin
            m_data_reg <= m_data_next;
            m_user_reg <= b1_we_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule

// ===== rtl/rgb565_alpha_blit.sv =====
// Top level of the RGB565 sprite alpha blit: front end, queue and blend unit.
//
//   channel   dir  contents
//   s_axis    in   tdata: dest_col, dest_row, dest_pixel, src_pixel, src_alpha
//   m_axis    out  tdata: out_pixel; tuser: write_enable
//   cfg       in   clip_left, clip_top, clip_right, clip_bottom, global_opacity
//
// One pixel per clock sustained while m_axis_tready stays high; each stage passes one
// item per cycle unless stalled. An input transfer passes the front register, a queue
// slot, the blend product stage and the output register before m_axis_tvalid rises.
// Back-pressure fills the output and product stages, then the queue; s_axis_tready
// drops only when the queue is full and the front register holds an item.
// Synchronous reset empties every stage and loads the default clip window and opacity.
module rgb565_alpha_blit import rab_pkg::*; #(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [((COORD_BITS > OPACITY_W) ? COORD_BITS : OPACITY_W)-1:0] cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // from bit 0: dest_col, dest_row, dest_pixel, src_pixel, src_alpha, zero pad
    input  logic [((2*(COORD_BITS+1) + 2*PIX_W + ALPHA_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // out_pixel
    output logic                  m_axis_tuser    // write_enable
);

    logic       f_valid;
    logic       f_ready;
    rab_item_t  f_item;
    logic       q_valid;
    logic       q_ready;
    rab_item_t  q_item;
    rab_qstat_t q_stat;

    rab_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .f_valid   (f_valid),
        .f_ready   (f_ready),
        .f_item    (f_item)
    );

    rab_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item),
        .stat      (q_stat)
    );

    rab_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata),
        .m_user   (m_axis_tuser)
    );

    // Input stalls only when the front register is held by a full queue
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (f_valid && q_stat.full))
        else $error("input stalled without a full queue");

    // Queue status is never full and empty together
    a_qstat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== bench/rgb565_alpha_blit_tb.sv =====
// Self-checking bench for the RGB565 alpha blit: streams pixels, predicts each blend, checks it.
`timescale 1ns / 1ps

module rgb565_alpha_blit_tb import rab_pkg::*; ();

    localparam int COORD_BITS   = DEF_COORD_BITS;
    localparam int IN_CW        = COORD_BITS + 1;
    localparam int CFG_W        = (COORD_BITS > OPACITY_W) ? COORD_BITS : OPACITY_W;
    localparam int TDATA_W      = ((2*(COORD_BITS+1) + 2*PIX_W + ALPHA_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int WIN_MAX      = 1 << (COORD_BITS - 1);

    // one sprite pixel as sent on s_axis
    typedef struct {
        logic signed [COORD_BITS:0] col;
        logic signed [COORD_BITS:0] row;
        logic [PIX_W-1:0]           dpx;
        logic [PIX_W-1:0]           spx;
        logic [ALPHA_W-1:0]         alpha;
    } sprite_px_t;

    // one frame pixel as returned on m_axis
    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             wr;
    } frame_px_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CLIP_LEFT;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // from bit 0: dest_col, dest_row, dest_pixel, src_pixel, src_alpha, zero pad
    logic [TDATA_W-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIX_W-1:0]     m_axis_tdata;   // out_pixel
    logic                 m_axis_tuser;   // write_enable

    // local copy of the register file
    logic [COORD_BITS-2:0] win_left;
    logic [COORD_BITS-2:0] win_top;
    logic [COORD_BITS-1:0] win_right;
    logic [COORD_BITS-1:0] win_bottom;
    logic [OPACITY_W-1:0]  opacity;

    frame_px_t expected_px_q[$];

    int  mismatches = 0;
    int  pixels_sent = 0;
    int  pixels_checked = 0;
    int  pixels_written = 0;
    int  reg_writes = 0;
    int  cycle_count = 0;
    int  sink_stall_left = 0;
    bit  src_gaps_on = 1'b0;
    bit  sink_stalls_on = 1'b0;

    rgb565_alpha_blit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_px_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Blend prediction
    // ---------------------------------------------------------------------

    // d + floor((s - d) * a / 256)
    function automatic int mix_channel(input int d, input int s, input int a);
        int prod;
        prod = (s - d) * a;
        return d + (prod >>> 8);
    endfunction

    function automatic frame_px_t blend_pixel(input sprite_px_t px);
        frame_px_t res;
        int col, row, a;
        int l, t, r, b;
        bit in_win;
        col = int'(px.col);
        row = int'(px.row);
        l = int'(win_left);
        t = int'(win_top);
        r = int'(win_right);
        b = int'(win_bottom);
        in_win = (col >= l) && (col < r) && (row >= t) && (row < b);
        res.pixel = px.dpx;
        res.wr = 1'b0;
        if (in_win && px.alpha != '0) begin
            res.wr = 1'b1;
            a = int'(px.alpha);
            // opacity at or above full leaves coverage alone
            if (opacity < OPACITY_FULL)
                a = (a * int'(opacity)) >> 8;
            if (a >= int'(ALPHA_OPAQUE)) begin
                res.pixel = px.spx;
            end else begin
                res.pixel[R_LSB +: R_W] = R_W'(mix_channel(int'(px.dpx[R_LSB +: R_W]),
                                                           int'(px.spx[R_LSB +: R_W]), a));
                res.pixel[G_LSB +: G_W] = G_W'(mix_channel(int'(px.dpx[G_LSB +: G_W]),
                                                           int'(px.spx[G_LSB +: G_W]), a));
                res.pixel[B_LSB +: B_W] = B_W'(mix_channel(int'(px.dpx[B_LSB +: B_W]),
                                                           int'(px.spx[B_LSB +: B_W]), a));
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        if (r < 93)
            return $urandom_range(3, 6);
        return $urandom_range(12, 40);
    endfunction

    // coordinate biased toward the window and its edges
    function automatic logic signed [COORD_BITS:0] pick_coord(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return IN_CW'((hi > lo) ? int'($urandom_range(lo, hi - 1)) : lo);
        if (r < 70)
            return IN_CW'((($urandom_range(0, 1) != 0) ? lo : hi) +
                          int'($urandom_range(0, 3)) - 2);
        if (r < 85)
            return IN_CW'($urandom);
        return IN_CW'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    function automatic logic [PIX_W-1:0] pick_color();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        if (r < 4)
            return ALPHA_OPAQUE;
        if (r == 4)
            return 8'd1;
        if (r == 5)
            return ALPHA_W'(ALPHA_OPAQUE - 8'd1);
        return ALPHA_W'($urandom);
    endfunction

    function automatic sprite_px_t make_pixel(input int col, input int row,
                                              input logic [PIX_W-1:0] dpx,
                                              input logic [PIX_W-1:0] spx,
                                              input logic [ALPHA_W-1:0] alpha);
        sprite_px_t px;
        px.col = IN_CW'(col);
        px.row = IN_CW'(row);
        px.dpx = dpx;
        px.spx = spx;
        px.alpha = alpha;
        return px;
    endfunction

    function automatic sprite_px_t random_pixel();
        return make_pixel(int'(pick_coord(int'(win_left), int'(win_right))),
                          int'(pick_coord(int'(win_top), int'(win_bottom))),
                          pick_color(), pick_color(), pick_alpha());
    endfunction

    // ---------------------------------------------------------------------
    // Stream and register drivers
    // ---------------------------------------------------------------------

    // one s_axis transfer; the prediction is queued when it is accepted
    task automatic send_pixel(input sprite_px_t px);
        int gap;
        @(negedge aclk);
        if (src_gaps_on && $urandom_range(0, 2) == 0) begin
            gap = pick_gap_len();
            s_axis_tvalid = 1'b0;
            s_axis_tdata = TDATA_W'({$urandom, $urandom, $urandom});
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata = TDATA_W'({px.alpha, px.spx, px.dpx, px.row, px.col});
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        expected_px_q.push_back(blend_pixel(px));
        pixels_sent++;
    endtask

    // stop sending and wait for every result to come back
    task automatic drain_pipeline();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (expected_px_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_CLIP_LEFT:      win_left = value[COORD_BITS-2:0];
            REG_CLIP_TOP:       win_top = value[COORD_BITS-2:0];
            REG_CLIP_RIGHT:     win_right = value[COORD_BITS-1:0];
            REG_CLIP_BOTTOM:    win_bottom = value[COORD_BITS-1:0];
            REG_GLOBAL_OPACITY: opacity = value[OPACITY_W-1:0];
            default: ;  // unused index, block ignores it
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
        reg_writes++;
    endtask

    task automatic set_window(input int l, input int t, input int r, input int b);
        write_reg(REG_CLIP_LEFT, CFG_W'(l));
        write_reg(REG_CLIP_TOP, CFG_W'(t));
        write_reg(REG_CLIP_RIGHT, CFG_W'(r));
        write_reg(REG_CLIP_BOTTOM, CFG_W'(b));
    endtask

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------

    // sink back-pressure, changes at the falling edge
    always @(negedge aclk) begin
        if (sink_stall_left > 0) begin
            m_axis_tready = 1'b0;
            sink_stall_left--;
        end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
            m_axis_tready = 1'b0;
            sink_stall_left = pick_gap_len() - 1;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // compare each m_axis transfer with the oldest prediction
    always @(posedge aclk) begin
        frame_px_t exp_px;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_px_q.size() == 0) begin
                $display("%0t: result with none expected, got pixel %h write_enable %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                exp_px = expected_px_q.pop_front();
                if (m_axis_tdata !== exp_px.pixel) begin
                    $display("%0t: out_pixel expected %h, got %h", $time,
                             exp_px.pixel, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== exp_px.wr) begin
                    $display("%0t: write_enable expected %b, got %b", $time,
                             exp_px.wr, m_axis_tuser);
                    mismatches++;
                end
                pixels_checked++;
                if (exp_px.wr)
                    pixels_written++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // default window and opacity: coordinate and color extremes, alpha corners
    task automatic test_directed_corners();
        send_pixel(make_pixel(0, 0, 16'h0000, 16'hFFFF, ALPHA_OPAQUE));
        send_pixel(make_pixel(0, 0, 16'hFFFF, 16'h0000, ALPHA_OPAQUE));
        send_pixel(make_pixel(0, 0, 16'h1234, 16'hABCD, 8'd0));
        send_pixel(make_pixel(0, 0, 16'h0000, 16'hFFFF, 8'd1));
        // negative channel difference rounds toward minus infinity
        send_pixel(make_pixel(0, 0, 16'hFFFF, 16'h0000, 8'd1));
        send_pixel(make_pixel(2047, 2047, 16'hF800, 16'h07E0, 8'd128));
        send_pixel(make_pixel(2047, 0, 16'h001F, 16'hF800, 8'd254));
        send_pixel(make_pixel(-1, 0, 16'h4321, 16'hFFFF, 8'd200));
        send_pixel(make_pixel(0, -1, 16'h4321, 16'hFFFF, 8'd200));
        send_pixel(make_pixel(2048, 0, 16'h4321, 16'hFFFF, 8'd200));
        send_pixel(make_pixel(0, 2048, 16'h4321, 16'hFFFF, 8'd200));
        send_pixel(make_pixel(-4096, -4096, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_pixel(make_pixel(4095, 4095, 16'hFFFF, 16'h0000, 8'hFF));
        send_pixel(make_pixel(-2048, 100, 16'h8001, 16'h7FFE, 8'd64));
        send_pixel(make_pixel(100, -2048, 16'h8001, 16'h7FFE, 8'd64));
        send_pixel(make_pixel(1000, 1000, 16'h5555, 16'hAAAA, 8'd127));
        send_pixel(make_pixel(1000, 1000, 16'hAAAA, 16'h5555, 8'd129));
        send_pixel(make_pixel(4095, -1, 16'h0F0F, 16'hF0F0, 8'd90));
        drain_pipeline();
    endtask

    // window edges, empty and extreme windows, unused register indexes
    task automatic test_clip_edges();
        int cols[4];
        int rows[4];
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        set_window(100, 50, 200, 120);
        cols = '{99, 100, 199, 200};
        rows = '{49, 50, 119, 120};
        foreach (cols[i])
            foreach (rows[j])
                send_pixel(make_pixel(cols[i], rows[j], pick_color(), pick_color(),
                                      ALPHA_W'($urandom_range(1, 255))));
        drain_pipeline();
        // writes to unused indexes must leave the window alone
        for (int idx = int'(REG_GLOBAL_OPACITY) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), CFG_W'($urandom));
        send_pixel(make_pixel(100, 50, 16'h1111, 16'hEEEE, 8'd100));
        send_pixel(make_pixel(99, 50, 16'h1111, 16'hEEEE, 8'd100));
        drain_pipeline();
        // left at right: empty window
        set_window(300, 300, 300, 300);
        send_pixel(make_pixel(300, 300, 16'h1234, 16'h4321, ALPHA_OPAQUE));
        send_pixel(make_pixel(299, 299, 16'h1234, 16'h4321, ALPHA_OPAQUE));
        drain_pipeline();
        // left past right
        set_window(500, 60, 400, 100);
        send_pixel(make_pixel(450, 80, 16'h1234, 16'h4321, 8'd77));
        drain_pipeline();
        // single pixel at the far corner
        set_window(2047, 2047, 2048, 2048);
        send_pixel(make_pixel(2047, 2047, 16'h0000, 16'hFFFF, 8'd200));
        send_pixel(make_pixel(2046, 2047, 16'h0000, 16'hFFFF, 8'd200));
        send_pixel(make_pixel(2047, 2048, 16'h0000, 16'hFFFF, 8'd200));
        drain_pipeline();
        // all-ones writes: left masks to its top value, right reaches past the canvas
        set_window(4095, 0, 4095, 4095);
        send_pixel(make_pixel(2047, 0, 16'h0F0F, 16'hF0F0, 8'd33));
        send_pixel(make_pixel(4094, 4094, 16'h0F0F, 16'hF0F0, 8'd33));
        send_pixel(make_pixel(4095, 5, 16'h0F0F, 16'hF0F0, 8'd33));
        send_pixel(make_pixel(2046, 5, 16'h0F0F, 16'hF0F0, 8'd33));
        drain_pipeline();
        // zero-size window at the origin
        set_window(0, 0, 0, 0);
        send_pixel(make_pixel(0, 0, 16'h0F0F, 16'hF0F0, ALPHA_OPAQUE));
        drain_pipeline();
    endtask

    // coverage scaled by a range of opacity settings, including masked writes
    task automatic test_opacity_levels();
        int levels[10];
        levels = '{0, 1, 2, 128, 255, 256, 257, 511, 4095, 768};
        set_window(0, 0, WIN_MAX, WIN_MAX);
        foreach (levels[i]) begin
            drain_pipeline();
            write_reg(REG_GLOBAL_OPACITY, CFG_W'(levels[i]));
            send_pixel(make_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
                                  pick_color(), pick_color(), ALPHA_OPAQUE));
            send_pixel(make_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
                                  pick_color(), pick_color(), 8'd1));
            repeat (6)
                send_pixel(make_pixel($urandom_range(0, 2047), $urandom_range(0, 2047),
                                      pick_color(), pick_color(), pick_alpha()));
        end
        drain_pipeline();
    endtask

    // random windows and opacity, random pixels, idling switched per phase
    task automatic test_random_traffic();
        int kind, l, t, r, b, op_kind;
        for (int phase = 0; phase < 8; phase++) begin
            drain_pipeline();
            src_gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                l = 0; t = 0; r = WIN_MAX; b = WIN_MAX;
            end else if (kind == 1) begin
                l = $urandom_range(0, 2047); t = $urandom_range(0, 2047);
                r = $urandom_range(0, l); b = $urandom_range(0, 4095);
            end else if (kind == 2) begin
                l = $urandom; t = $urandom; r = $urandom; b = $urandom;
            end else begin
                l = $urandom_range(0, 1900); t = $urandom_range(0, 1900);
                r = l + $urandom_range(1, 400); b = t + $urandom_range(1, 400);
            end
            set_window(l, t, r, b);
            op_kind = $urandom_range(0, 9);
            case (op_kind)
                0, 1, 2, 3: write_reg(REG_GLOBAL_OPACITY, CFG_W'(OPACITY_FULL));
                4:          write_reg(REG_GLOBAL_OPACITY, '0);
                5:          write_reg(REG_GLOBAL_OPACITY, CFG_W'(255));
                6:          write_reg(REG_GLOBAL_OPACITY, CFG_W'($urandom_range(257, 4095)));
                default:    write_reg(REG_GLOBAL_OPACITY, CFG_W'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_GLOBAL_OPACITY) + 1,
                                                    (1 << CFG_IDX_W) - 1)), CFG_W'($urandom));
            repeat (56)
                send_pixel(random_pixel());
        end
        drain_pipeline();
    endtask

    initial begin
        // register file after reset
        win_left = '0;
        win_top = '0;
        win_right = COORD_BITS'(WIN_MAX);
        win_bottom = COORD_BITS'(WIN_MAX);
        opacity = OPACITY_FULL;

        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_corners();
        test_clip_edges();
        test_opacity_levels();
        test_random_traffic();

        $display("Checked %0d pixels (%0d written, %0d passed through) over %0d register writes,",
                 pixels_checked, pixels_written, pixels_checked - pixels_written, reg_writes);
        $display("covering clip edges, empty windows, opacity scaling and stalls on both sides.");
        if (mismatches == 0 && pixels_checked == pixels_sent) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
